>>> design/bar_pkg.sv
// Shared types, constants and helper functions for the block-ack reorder window.
package bar_pkg;

	// Sizing
	localparam int MAX_WINDOW = 32;
	localparam int SEQ_BITS   = 12;
	localparam int SEQ_SPACE  = 1 << SEQ_BITS;
	localparam int SEQ_LAST   = SEQ_SPACE - 1;
	localparam int SLOT_BITS  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int W_BITS     = $clog2(MAX_WINDOW + 1);
	localparam int CNT_BITS   = 6;

	// Field widths of the ports
	localparam int TAG_W      = 16;
	localparam int SEQ_W      = 12;
	localparam int WS_W       = 6;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;

	// Remainder unit: bits retired per cycle and resulting cycle count
	localparam int MOD_STEP  = 4;
	localparam int MOD_CYC   = (SEQ_BITS + MOD_STEP - 1) / MOD_STEP;
	localparam int MOD_PAD   = MOD_CYC * MOD_STEP;
	localparam int MOD_CNT_W = $clog2(MOD_CYC + 1);

	// Codes
	localparam logic OP_FRAME    = 1'b0;
	localparam logic OP_FLUSH    = 1'b1;
	localparam logic ACT_DELIVER = 1'b0;
	localparam logic ACT_DROP    = 1'b1;

	typedef logic [SEQ_BITS-1:0]  seq_t;
	typedef logic [SLOT_BITS-1:0] slot_t;
	typedef logic [W_BITS-1:0]    win_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SESSION_ACTIVE = 2'd0,
		CFG_START_SEQ      = 2'd1,
		CFG_WINDOW_SIZE    = 2'd2
	} cfg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_START,
		S_FRESH,
		S_FIRST,
		S_CLASS,
		S_SEQMOD,
		S_SLIDE,
		S_HEADMOD,
		S_PLACE,
		S_RUN,
		S_FINISH
	} state_t;

	typedef enum logic [1:0] {
		MSEL_HEAD,
		MSEL_SEQ,
		MSEL_TARGET
	} mod_sel_t;

	typedef enum logic [1:0] {
		ESRC_SLOT,
		ESRC_DROP,
		ESRC_PASS
	} emit_src_t;

	// Request and result payloads
	typedef struct packed {
		logic             opcode;
		logic [SEQ_W-1:0] seq_num;
		logic [TAG_W-1:0] frame_tag;
	} in_item_t;

	typedef struct packed {
		logic [TAG_W-1:0] out_tag;
		logic             action;
		logic             last;
	} out_item_t;

	// Controller to datapath
	typedef struct packed {
		logic      ld_item;
		logic      mod_start;
		mod_sel_t  mod_sel;
		logic      head_slot_ld;
		logic      seq_slot_ld;
		logic      first_adjust;
		logic      tgt_flush;
		logic      tgt_slide;
		logic      jump_head;
		logic      rel_step;
		logic      pass_step;
		logic      store;
		logic      emit;
		emit_src_t emit_src;
		logic      finish;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic is_flush;
		logic active;
		logic stale;
		logic old;
		logic beyond;
		logic mod_done;
		logic slide_more;
		logic head_valid;
		logic seq_valid;
		logic pass_ok;
		logic can_emit;
		logic hold_valid;
		logic out_free;
	} status_t;

	// a lies before b in modulo sequence space
	function automatic logic seq_before(input seq_t a, input seq_t b);
		seq_t d;
		d = a - b;
		return d > SEQ_BITS'(SEQ_SPACE >> 1);
	endfunction

	// Window size clamped to 1..MAX_WINDOW
	function automatic win_t eff_window(input logic [WS_W-1:0] ws);
		win_t w;
		if (ws == '0) begin
			w = W_BITS'(1);
		end else if (ws > WS_W'(MAX_WINDOW)) begin
			w = W_BITS'(MAX_WINDOW);
		end else begin
			w = W_BITS'(ws);
		end
		return w;
	endfunction

	// Sequence field reduced to the modulo width
	function automatic seq_t seq_of(input logic [SEQ_W-1:0] s);
		return SEQ_BITS'(s);
	endfunction

endpackage

>>> design/bar_mod.sv
// Iterative remainder unit: sequence distance modulo the window size.
module bar_mod (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  bar_pkg::seq_t        dividend,
	input  bar_pkg::win_t        divisor,
	output logic                 done,
	output bar_pkg::slot_t       rem
);

	logic                            busy_q;
	logic                            done_q;
	logic [bar_pkg::MOD_CNT_W-1:0]   cnt_q;
	logic [bar_pkg::MOD_PAD-1:0]     shift_q;
	logic [bar_pkg::W_BITS-1:0]      rem_q;
	logic [bar_pkg::MOD_PAD-1:0]     shift_nxt;
	logic [bar_pkg::W_BITS-1:0]      rem_nxt;

	// Restoring remainder, MOD_STEP dividend bits per cycle, MSB first
	always_comb begin : step_blk
		logic [bar_pkg::W_BITS:0] t;
		rem_nxt   = rem_q;
		shift_nxt = shift_q;
		for (int k = 0; k < bar_pkg::MOD_STEP; k++) begin
			t = {rem_nxt, shift_nxt[bar_pkg::MOD_PAD-1]};
			if (t >= {1'b0, divisor}) begin
				t = t - {1'b0, divisor};
			end
			rem_nxt   = t[bar_pkg::W_BITS-1:0];
			shift_nxt = shift_nxt << 1;
		end
	end

	// Sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= bar_pkg::MOD_CNT_W'(bar_pkg::MOD_CYC);
		end else if (busy_q) begin
			cnt_q <= cnt_q - bar_pkg::MOD_CNT_W'(1);
			if (cnt_q == bar_pkg::MOD_CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		if (start) begin
			shift_q <= bar_pkg::MOD_PAD'(dividend);
			rem_q   <= '0;
		end else if (busy_q) begin
			shift_q <= shift_nxt;
			rem_q   <= rem_nxt;
		end
	end

	assign done = done_q;
	assign rem  = bar_pkg::SLOT_BITS'(rem_q);

endmodule

>>> design/bar_dp.sv
// Datapath: configuration, window state, slot store, remainder unit and result registers.
module bar_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  bar_pkg::in_item_t                frame,
	input  logic                             cfg_we,
	input  logic [bar_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bar_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             result_ready,
	output logic                             result_valid,
	output bar_pkg::out_item_t               result,
	input  bar_pkg::cmd_t                    cmd,
	output bar_pkg::status_t                 st
);

	// Configuration
	logic                          active_q;
	logic [bar_pkg::SEQ_W-1:0]     start_seq_q;
	logic [bar_pkg::WS_W-1:0]      ws_q;

	// Window state
	logic [bar_pkg::MAX_WINDOW-1:0] valid_q;
	logic [bar_pkg::TAG_W-1:0]      slot_tag_q [bar_pkg::MAX_WINDOW];
	bar_pkg::seq_t                  head_q;
	bar_pkg::seq_t                  base_q;
	bar_pkg::slot_t                 head_slot_q;
	bar_pkg::slot_t                 seq_slot_q;
	bar_pkg::seq_t                  target_q;
	logic [bar_pkg::CNT_BITS-1:0]   count_q;
	logic                           first_q;
	logic                           stale_q;
	bar_pkg::in_item_t              item_q;

	// Hold stage and result register
	logic                           hold_valid_q;
	logic [bar_pkg::TAG_W-1:0]      hold_tag_q;
	logic                           hold_act_q;
	logic                           out_valid_q;
	bar_pkg::out_item_t             out_q;

	bar_pkg::win_t                  w;
	bar_pkg::seq_t                  seq_w;
	bar_pkg::seq_t                  head_dist;
	bar_pkg::seq_t                  mod_dividend;
	logic                           mod_done;
	bar_pkg::slot_t                 mod_rem;
	logic [bar_pkg::W_BITS-1:0]     slot_plus;
	bar_pkg::slot_t                 slot_inc;
	logic [bar_pkg::TAG_W-1:0]      emit_tag;
	logic                           emit_act;
	logic                           out_free;
	logic                           push;
	logic                           sess_start;

	assign w          = bar_pkg::eff_window(ws_q);
	assign seq_w      = bar_pkg::seq_of(item_q.seq_num);
	assign head_dist  = head_q - base_q;
	assign sess_start = cfg_we && (cfg_index == bar_pkg::CFG_SESSION_ACTIVE);

	// Slot of head + 1, wrapping at the window and at the sequence modulus
	assign slot_plus = bar_pkg::W_BITS'(head_slot_q) + bar_pkg::W_BITS'(1);
	always_comb begin
		priority if (head_dist == bar_pkg::SEQ_BITS'(bar_pkg::SEQ_LAST)) begin
			slot_inc = '0;
		end else if (slot_plus == w) begin
			slot_inc = '0;
		end else begin
			slot_inc = bar_pkg::SLOT_BITS'(slot_plus);
		end
	end

	// Remainder unit operand
	always_comb begin
		unique case (cmd.mod_sel)
			bar_pkg::MSEL_HEAD:   mod_dividend = head_q - base_q;
			bar_pkg::MSEL_SEQ:    mod_dividend = seq_w - base_q;
			bar_pkg::MSEL_TARGET: mod_dividend = target_q - base_q;
			default:              mod_dividend = head_q - base_q;
		endcase
	end

	bar_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.mod_start),
		.dividend (mod_dividend),
		.divisor  (w),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	// Result source
	always_comb begin
		unique case (cmd.emit_src)
			bar_pkg::ESRC_SLOT: begin
				emit_tag = slot_tag_q[head_slot_q];
				emit_act = bar_pkg::ACT_DELIVER;
			end
			bar_pkg::ESRC_DROP: begin
				emit_tag = item_q.frame_tag;
				emit_act = bar_pkg::ACT_DROP;
			end
			bar_pkg::ESRC_PASS: begin
				emit_tag = item_q.frame_tag;
				emit_act = bar_pkg::ACT_DELIVER;
			end
			default: begin
				emit_tag = item_q.frame_tag;
				emit_act = bar_pkg::ACT_DELIVER;
			end
		endcase
	end

	assign out_free = !out_valid_q || result_ready;
	assign push     = (cmd.emit && hold_valid_q) || cmd.finish;

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q     <= 1'b0;
			start_seq_q  <= '0;
			ws_q         <= bar_pkg::WS_W'(32);
			valid_q      <= '0;
			head_q       <= '0;
			base_q       <= '0;
			head_slot_q  <= '0;
			count_q      <= '0;
			first_q      <= 1'b1;
			stale_q      <= 1'b0;
			hold_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			// Result register and hold stage
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.emit) begin
				hold_valid_q <= 1'b1;
			end else if (cmd.finish) begin
				hold_valid_q <= 1'b0;
			end

			if (sess_start) begin
				// New session: window back to the start sequence, store emptied
				active_q    <= cfg_data[0];
				head_q      <= bar_pkg::seq_of(start_seq_q);
				base_q      <= bar_pkg::seq_of(start_seq_q);
				head_slot_q <= '0;
				stale_q     <= 1'b0;
				valid_q     <= '0;
				count_q     <= '0;
				first_q     <= 1'b1;
			end else begin
				if (cfg_we && (cfg_index == bar_pkg::CFG_START_SEQ)) begin
					start_seq_q <= cfg_data[bar_pkg::SEQ_W-1:0];
				end
				if (cfg_we && (cfg_index == bar_pkg::CFG_WINDOW_SIZE)) begin
					ws_q    <= cfg_data[bar_pkg::WS_W-1:0];
					stale_q <= 1'b1;
				end
				// First frame resynchronises the window
				if (cmd.first_adjust && first_q) begin
					first_q <= 1'b0;
					if (seq_w != head_q) begin
						head_q      <= seq_w;
						base_q      <= seq_w;
						head_slot_q <= '0;
						stale_q     <= 1'b0;
					end
				end
				if (cmd.jump_head) begin
					head_q  <= target_q;
					stale_q <= 1'b1;
				end
				if (cmd.head_slot_ld) begin
					head_slot_q <= mod_rem;
					stale_q     <= 1'b0;
				end
				if (cmd.rel_step || cmd.pass_step) begin
					head_q      <= head_q + bar_pkg::SEQ_BITS'(1);
					head_slot_q <= slot_inc;
				end
				if (cmd.rel_step && valid_q[head_slot_q]) begin
					valid_q[head_slot_q] <= 1'b0;
					if (count_q != '0) begin
						count_q <= count_q - bar_pkg::CNT_BITS'(1);
					end
				end
				if (cmd.store) begin
					valid_q[seq_slot_q] <= 1'b1;
					count_q             <= count_q + bar_pkg::CNT_BITS'(1);
				end
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.ld_item) begin
			item_q <= frame;
		end
		if (cmd.seq_slot_ld) begin
			seq_slot_q <= mod_rem;
		end
		if (cmd.tgt_flush) begin
			target_q <= head_q + bar_pkg::SEQ_BITS'(w);
		end else if (cmd.tgt_slide) begin
			target_q <= seq_w - bar_pkg::SEQ_BITS'(w) + bar_pkg::SEQ_BITS'(1);
		end
		if (cmd.store) begin
			slot_tag_q[seq_slot_q] <= item_q.frame_tag;
		end
		if (cmd.emit) begin
			hold_tag_q <= emit_tag;
			hold_act_q <= emit_act;
		end
		if (push) begin
			out_q.out_tag <= hold_tag_q;
			out_q.action  <= hold_act_q;
			out_q.last    <= cmd.finish;
		end
	end

	// Status to the controller
	assign st.is_flush   = (item_q.opcode == bar_pkg::OP_FLUSH);
	assign st.active     = active_q;
	assign st.stale      = stale_q;
	assign st.old        = bar_pkg::seq_before(seq_w, head_q);
	assign st.beyond     = !bar_pkg::seq_before(seq_w, head_q + bar_pkg::SEQ_BITS'(w));
	assign st.mod_done   = mod_done;
	assign st.slide_more = bar_pkg::seq_before(head_q, target_q) && (count_q != '0);
	assign st.head_valid = valid_q[head_slot_q];
	assign st.seq_valid  = valid_q[seq_slot_q];
	assign st.pass_ok    = (seq_w == head_q) && (count_q == '0);
	assign st.can_emit   = !hold_valid_q || out_free;
	assign st.hold_valid = hold_valid_q;
	assign st.out_free   = out_free;

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

>>> design/bar_ctrl.sv
// Controller state machine sequencing one request through the reorder window.
module bar_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              frame_valid,
	output logic              frame_ready,
	input  bar_pkg::status_t  st,
	output bar_pkg::cmd_t     cmd
);

	bar_pkg::state_t state_q;
	bar_pkg::state_t state_nxt;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bar_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			bar_pkg::S_IDLE: begin
				if (frame_valid) state_nxt = bar_pkg::S_START;
			end
			bar_pkg::S_START: begin
				if (st.is_flush || st.active) begin
					state_nxt = st.stale ? bar_pkg::S_FRESH : bar_pkg::S_FIRST;
				end else if (st.can_emit) begin
					state_nxt = bar_pkg::S_FINISH;
				end
			end
			bar_pkg::S_FRESH: begin
				if (st.mod_done) state_nxt = bar_pkg::S_FIRST;
			end
			bar_pkg::S_FIRST: begin
				state_nxt = st.is_flush ? bar_pkg::S_SLIDE : bar_pkg::S_CLASS;
			end
			bar_pkg::S_CLASS: begin
				if (st.old) begin
					if (st.can_emit) state_nxt = bar_pkg::S_FINISH;
				end else begin
					state_nxt = bar_pkg::S_SEQMOD;
				end
			end
			bar_pkg::S_SEQMOD: begin
				if (st.mod_done) begin
					state_nxt = st.beyond ? bar_pkg::S_SLIDE : bar_pkg::S_PLACE;
				end
			end
			bar_pkg::S_SLIDE: begin
				if (!st.slide_more) begin
					state_nxt = st.is_flush ? bar_pkg::S_FINISH : bar_pkg::S_HEADMOD;
				end
			end
			bar_pkg::S_HEADMOD: begin
				if (st.mod_done) state_nxt = bar_pkg::S_PLACE;
			end
			bar_pkg::S_PLACE: begin
				if (st.seq_valid || st.pass_ok) begin
					if (st.can_emit) state_nxt = bar_pkg::S_FINISH;
				end else begin
					state_nxt = bar_pkg::S_RUN;
				end
			end
			bar_pkg::S_RUN: begin
				if (!st.head_valid) state_nxt = bar_pkg::S_FINISH;
			end
			bar_pkg::S_FINISH: begin
				if (!st.hold_valid || st.out_free) state_nxt = bar_pkg::S_IDLE;
			end
			default: state_nxt = bar_pkg::S_IDLE;
		endcase
	end

	// Commands
	always_comb begin
		cmd          = '0;
		cmd.mod_sel  = bar_pkg::MSEL_HEAD;
		cmd.emit_src = bar_pkg::ESRC_SLOT;
		frame_ready  = 1'b0;
		unique case (state_q)
			bar_pkg::S_IDLE: begin
				frame_ready = 1'b1;
				cmd.ld_item = frame_valid;
			end
			bar_pkg::S_START: begin
				if (!(st.is_flush || st.active)) begin
					// Session off: frame goes straight up
					cmd.emit     = st.can_emit;
					cmd.emit_src = bar_pkg::ESRC_PASS;
				end else if (st.stale) begin
					cmd.mod_start = 1'b1;
					cmd.mod_sel   = bar_pkg::MSEL_HEAD;
				end
			end
			bar_pkg::S_FRESH: begin
				cmd.head_slot_ld = st.mod_done;
			end
			bar_pkg::S_FIRST: begin
				if (st.is_flush) begin
					cmd.tgt_flush = 1'b1;
				end else begin
					cmd.first_adjust = 1'b1;
				end
			end
			bar_pkg::S_CLASS: begin
				if (st.old) begin
					cmd.emit     = st.can_emit;
					cmd.emit_src = bar_pkg::ESRC_DROP;
				end else begin
					cmd.mod_start = 1'b1;
					cmd.mod_sel   = bar_pkg::MSEL_SEQ;
					cmd.tgt_slide = 1'b1;
				end
			end
			bar_pkg::S_SEQMOD: begin
				cmd.seq_slot_ld = st.mod_done;
			end
			bar_pkg::S_SLIDE: begin
				if (st.slide_more) begin
					// Step the head; wait only when a stored frame cannot be handed on
					if (!(st.head_valid && !st.can_emit)) begin
						cmd.rel_step = 1'b1;
						cmd.emit     = st.head_valid;
						cmd.emit_src = bar_pkg::ESRC_SLOT;
					end
				end else begin
					cmd.jump_head = 1'b1;
					if (!st.is_flush) begin
						cmd.mod_start = 1'b1;
						cmd.mod_sel   = bar_pkg::MSEL_TARGET;
					end
				end
			end
			bar_pkg::S_HEADMOD: begin
				cmd.head_slot_ld = st.mod_done;
			end
			bar_pkg::S_PLACE: begin
				if (st.seq_valid) begin
					// Duplicate
					cmd.emit     = st.can_emit;
					cmd.emit_src = bar_pkg::ESRC_DROP;
				end else if (st.pass_ok) begin
					cmd.pass_step = st.can_emit;
					cmd.emit      = st.can_emit;
					cmd.emit_src  = bar_pkg::ESRC_PASS;
				end else begin
					cmd.store = 1'b1;
				end
			end
			bar_pkg::S_RUN: begin
				if (st.head_valid && st.can_emit) begin
					cmd.rel_step = 1'b1;
					cmd.emit     = 1'b1;
					cmd.emit_src = bar_pkg::ESRC_SLOT;
				end
			end
			bar_pkg::S_FINISH: begin
				cmd.finish = st.hold_valid && st.out_free;
			end
			default: begin
				cmd.finish = 1'b0;
			end
		endcase
	end

endmodule

>>> design/block_ack_reorder_window_top.sv
// Top level of the block-ack receive reorder window.
// An in-order or out-of-order frame runs through the controller from acceptance to its last result;
// the remainder unit (4 distance bits per cycle) places it in a slot, and runs again to place the head after a slide.
// Stored frames are released in order behind it; a flush releases stored frames up to head plus the window size.
// A frame after a window size change first refreshes the head slot through the remainder unit.
// Reset is asynchronous: the store empties at once through its valid bits, no clearing pass.
module block_ack_reorder_window_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             frame_valid,
	output logic                             frame_ready,
	input  bar_pkg::in_item_t                frame,
	output logic                             result_valid,
	input  logic                             result_ready,
	output bar_pkg::out_item_t               result,
	input  logic                             cfg_we,
	input  logic [bar_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bar_pkg::CFG_DATA_W-1:0]   cfg_data
);

	bar_pkg::cmd_t    cmd;
	bar_pkg::status_t st;

	bar_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.frame_valid (frame_valid),
		.frame_ready (frame_ready),
		.st          (st),
		.cmd         (cmd)
	);

	bar_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.frame        (frame),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.result_ready (result_ready),
		.result_valid (result_valid),
		.result       (result),
		.cmd          (cmd),
		.st           (st)
	);

	// A result only enters the hold stage when it can move on
	a_emit_gated: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> st.can_emit)
		else $error("result produced while hold stage and result register are full");

	// The last result only leaves when the result register frees
	a_finish_gated: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (st.hold_valid && st.out_free))
		else $error("final result pushed without room");

	// A new request is taken only once the previous one has left the hold stage
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		frame_ready |-> !st.hold_valid)
		else $error("request accepted with a result still held");

	// The remainder unit is started once per computation
	a_mod_single: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mod_start |=> !cmd.mod_start)
		else $error("remainder unit restarted while busy");

endmodule

>>> dv/bar_window_checker.sv
// Reorder window checker: predicts every release from observed requests and compares.
module bar_window_checker
	import bar_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  frame_valid,
	input  logic                  frame_ready,
	input  in_item_t              frame,
	input  logic                  result_valid,
	input  logic                  result_ready,
	input  out_item_t             result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    pending,
	output int                    errors
);

	// Shadow registers
	logic            sess_on;
	seq_t            start_cfg;
	logic [WS_W-1:0] win_cfg;

	// Shadow window state
	logic             slot_full [MAX_WINDOW];
	logic [TAG_W-1:0] slot_handle [MAX_WINDOW];
	seq_t             head;
	seq_t             base;
	logic [5:0]       held;
	logic             awaiting_first;

	out_item_t due_releases [$];
	out_item_t want;
	int        released;
	int        mismatches = 0;

	assign errors = mismatches;

	// a is older than b in modulo sequence space
	function automatic logic lags(seq_t a, seq_t b);
		seq_t d;
		d = a - b;
		return d > seq_t'(SEQ_SPACE / 2);
	endfunction

	// slots in use, clamped to 1..MAX_WINDOW
	function automatic int slots_in_use();
		int w;
		w = int'(win_cfg);
		if (w < 1) w = 1;
		if (w > MAX_WINDOW) w = MAX_WINDOW;
		return w;
	endfunction

	function automatic int slot_index(seq_t s);
		seq_t d;
		d = s - base;
		return int'(d) % slots_in_use();
	endfunction

	task automatic push_release(logic [TAG_W-1:0] tag, logic act);
		out_item_t r;
		r.out_tag = tag;
		r.action  = act;
		r.last    = 1'b0;
		due_releases.push_back(r);
		released++;
	endtask

	// deliver whatever sits at the head, then step the head
	task automatic advance_head();
		int i;
		i = slot_index(head);
		if (slot_full[i]) begin
			slot_full[i] = 1'b0;
			if (held > 0) held--;
			push_release(slot_handle[i], ACT_DELIVER);
		end
		head = head + seq_t'(1);
	endtask

	task automatic release_to(seq_t target);
		int guard;
		guard = 0;
		while (lags(head, target) && held > 0 && guard < SEQ_SPACE) begin
			advance_head();
			guard++;
		end
		head = target;
	endtask

	task automatic release_run();
		int guard;
		guard = 0;
		while (slot_full[slot_index(head)] && guard < MAX_WINDOW) begin
			advance_head();
			guard++;
		end
	endtask

	task automatic restart_session();
		for (int i = 0; i < MAX_WINDOW; i++) begin
			slot_full[i]   = 1'b0;
			slot_handle[i] = '0;
		end
		head           = start_cfg;
		base           = start_cfg;
		held           = '0;
		awaiting_first = 1'b1;
	endtask

	task automatic apply_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		case (idx)
			CFG_SESSION_ACTIVE: begin
				sess_on = data[0];
				restart_session();
			end
			CFG_START_SEQ:   start_cfg = seq_t'(data);
			CFG_WINDOW_SIZE: win_cfg = data[WS_W-1:0];
			default: ;
		endcase
	endtask

	// expected releases for one accepted request
	task automatic reorder_request(in_item_t req);
		seq_t      s;
		int        w;
		int        i;
		out_item_t tail;
		s        = seq_t'(req.seq_num);
		w        = slots_in_use();
		released = 0;
		if (req.opcode == OP_FLUSH) begin
			release_to(head + seq_t'(w));
		end else if (!sess_on) begin
			push_release(req.frame_tag, ACT_DELIVER);
		end else begin
			// first frame of a session may resync the window
			if (awaiting_first) begin
				awaiting_first = 1'b0;
				if (s != head) begin
					head = s;
					base = s;
				end
			end
			if (lags(s, head)) begin
				push_release(req.frame_tag, ACT_DROP);
			end else begin
				if (!lags(s, head + seq_t'(w)))
					release_to(s - seq_t'(w) + seq_t'(1));
				i = slot_index(s);
				if (slot_full[i]) begin
					push_release(req.frame_tag, ACT_DROP);
				end else if (s == head && held == 0) begin
					head = head + seq_t'(1);
					push_release(req.frame_tag, ACT_DELIVER);
				end else begin
					slot_full[i]   = 1'b1;
					slot_handle[i] = req.frame_tag;
					held           = held + 6'd1;
					release_run();
				end
			end
		end
		if (released > 0) begin
			tail      = due_releases.pop_back();
			tail.last = 1'b1;
			due_releases.push_back(tail);
		end
	endtask

	task automatic flag_mismatch(string what, out_item_t exp_r, out_item_t got);
		if (mismatches < 10)
			$display("%s: expected tag %h action %0b last %0b, got tag %h action %0b last %0b",
				what, exp_r.out_tag, exp_r.action, exp_r.last, got.out_tag, got.action, got.last);
		mismatches++;
	endtask

	// compare releases, track writes and requests
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sess_on   = 1'b0;
			start_cfg = '0;
			win_cfg   = WS_W'(MAX_WINDOW);
			restart_session();
			due_releases.delete();
			pending <= 0;
		end else begin
			if (result_valid && result_ready) begin
				if (due_releases.size() == 0) begin
					flag_mismatch("Unexpected result", '0, result);
				end else begin
					want = due_releases.pop_front();
					if (want !== result) flag_mismatch("Result mismatch", want, result);
				end
			end
			if (cfg_we) apply_write(cfg_index, cfg_data);
			if (frame_valid && frame_ready) reorder_request(frame);
			pending <= due_releases.size();
		end
	end

endmodule

>>> dv/tb.sv
// Testbench top: drives requests and register writes into the reorder window, gives the verdict.
module tb;
	import bar_pkg::*;

	localparam int STALL_LIMIT   = 3000;
	localparam int SETTLE_CYCLES = 100;
	localparam int PHASES        = 10;
	localparam int PHASE_ITEMS   = 28;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	logic                  clk;
	logic                  arst_n;
	logic                  frame_valid;
	logic                  frame_ready;
	in_item_t              frame;
	logic                  result_valid;
	logic                  result_ready = 1'b0;
	out_item_t             result;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    pending;
	int                    errors;

	int   send_idle_pct  = 0;
	int   recv_stall_pct = 0;
	int   idle_cycles    = 0;
	int   sent;
	int   span;
	seq_t cursor;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	block_ack_reorder_window_top u_top (.*);

	bar_window_checker u_checker (.*);

	// receiver back-pressure
	always @(posedge clk) begin
		result_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// watchdog: nothing accepted for too long
	always @(posedge clk) begin
		if (!arst_n || (frame_valid && frame_ready) || (result_valid && result_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles == STALL_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	task automatic send_request(logic op, seq_t s, logic [TAG_W-1:0] tag);
		in_item_t req;
		req.opcode    = op;
		req.seq_num   = s;
		req.frame_tag = tag;
		while ($urandom_range(99) < send_idle_pct) begin
			frame_valid <= 1'b0;
			@(posedge clk);
		end
		frame       <= req;
		frame_valid <= 1'b1;
		do @(posedge clk); while (!frame_ready);
	endtask

	// wait for every release, then let a silent request finish
	task automatic settle();
		frame_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_index <= idx;
		cfg_data  <= data;
		cfg_we    <= 1'b1;
		@(posedge clk);
		cfg_we    <= 1'b0;
		@(posedge clk);
		if (idx == CFG_WINDOW_SIZE) begin
			span = int'(data[WS_W-1:0]);
			if (span < 1) span = 1;
			if (span > MAX_WINDOW) span = MAX_WINDOW;
		end
	endtask

	// a run of consecutive sequences, usually shuffled, with the odd duplicate
	task automatic send_burst();
		seq_t order [64];
		seq_t tmp;
		int   k;
		int   j;
		k = $urandom_range(span + 2, 1);
		for (int n = 0; n < k; n++) order[n] = cursor + seq_t'(n);
		if ($urandom_range(99) < 70) begin
			for (int n = k - 1; n > 0; n--) begin
				j        = $urandom_range(n, 0);
				tmp      = order[n];
				order[n] = order[j];
				order[j] = tmp;
			end
		end
		for (int n = 0; n < k; n++) begin
			send_request(OP_FRAME, order[n], 16'($urandom));
			if ($urandom_range(99) < 8)
				send_request(OP_FRAME, order[$urandom_range(n, 0)], 16'($urandom));
		end
		cursor = cursor + seq_t'(k);
		sent += k;
	endtask

	task automatic random_item();
		int   pick;
		seq_t s;
		pick = $urandom_range(99);
		if (pick < 68) begin
			send_burst();
		end else begin
			if (pick < 76) begin
				// behind the head
				s = cursor - seq_t'($urandom_range(2047, 1));
				send_request(OP_FRAME, s, 16'($urandom));
			end else if (pick < 86) begin
				// beyond the window: slides the head
				s = cursor + seq_t'(span + $urandom_range(2 * span, 0));
				send_request(OP_FRAME, s, 16'($urandom));
				cursor = s - seq_t'(span) + seq_t'(1);
			end else if (pick < 93) begin
				send_request(OP_FLUSH, seq_t'($urandom), 16'($urandom));
				cursor = cursor + seq_t'(span);
			end else begin
				send_request(OP_FRAME, seq_t'($urandom), 16'($urandom));
			end
			sent++;
		end
	endtask

	initial begin
		logic [CFG_DATA_W-1:0] wd;
		seq_t                  st;
		logic                  paused;
		arst_n      = 1'b0;
		frame_valid = 1'b0;
		frame       = '0;
		cfg_we      = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		cursor      = '0;
		span        = MAX_WINDOW;
		paused      = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// session off: pass-through, flush on an empty store
		send_request(OP_FRAME, 12'd0, 16'h0000);
		send_request(OP_FRAME, 12'hFFF, 16'hFFFF);
		send_request(OP_FLUSH, 12'h000, 16'h1234);

		// small window across the sequence wrap
		settle();
		write_reg(CFG_WINDOW_SIZE, 12'd4);
		write_reg(CFG_START_SEQ, 12'd4094);
		write_reg(CFG_SESSION_ACTIVE, 12'hFFF);
		send_request(OP_FRAME, 12'd4094, 16'hA001);
		send_request(OP_FRAME, 12'd0, 16'hA002);
		send_request(OP_FRAME, 12'd4095, 16'hA003);
		send_request(OP_FRAME, 12'd2, 16'hA004);
		send_request(OP_FRAME, 12'd2, 16'hA005);
		send_request(OP_FRAME, 12'd4090, 16'hA006);
		send_request(OP_FRAME, 12'd9, 16'hA007);
		send_request(OP_FRAME, 12'd7, 16'hA008);
		send_request(OP_FLUSH, 12'd0, 16'h0000);
		send_request(OP_FLUSH, 12'hFFF, 16'hFFFF);
		send_request(OP_FRAME, 12'd14, 16'hA009);

		// first frame away from the start sequence resyncs the window
		settle();
		write_reg(CFG_START_SEQ, 12'd100);
		write_reg(CFG_SESSION_ACTIVE, 12'd1);
		send_request(OP_FRAME, 12'd2000, 16'hB001);
		send_request(OP_FRAME, 12'd2002, 16'hB002);
		send_request(OP_FRAME, 12'd2001, 16'hB003);
		send_request(OP_FRAME, 12'd1990, 16'hB004);

		// random phases over several settings
		for (int p = 0; p < PHASES; p++) begin
			settle();
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
				default: begin send_idle_pct = 24; recv_stall_pct = 24; end
			endcase
			case (p % 5)
				0: wd = 12'd32;
				1: wd = 12'($urandom_range(1, 0));
				2: wd = 12'($urandom_range(31, 2));
				3: wd = {6'($urandom), 6'd63};
				default: wd = 12'($urandom);
			endcase
			write_reg(CFG_WINDOW_SIZE, wd);
			if (p == 0) st = '0;
			else if (p == 1) st = '1;
			else st = seq_t'($urandom);
			write_reg(CFG_START_SEQ, st);
			if (p == 4) write_reg(CFG_SPARE, 12'($urandom));
			// some phases keep the session and its store across a window change
			if (p % 3 != 2) begin
				write_reg(CFG_SESSION_ACTIVE, {11'($urandom), (p != 6)});
				cursor = st;
				if ($urandom_range(3) == 0) cursor = seq_t'($urandom);
			end
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				random_item();
				if (p == 3 && !paused && sent >= PHASE_ITEMS / 2) begin
					settle();
					paused = 1'b1;
				end
			end
		end

		settle();
		if (errors == 0 && pending == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
